@@ sv/knn_pkg.sv @@
package knn_pkg;

  // Sizes of the neighbor list and of the point.
  localparam int NEIGHBORS  = 5;
  localparam int MAX_DIMS   = 32;
  localparam int COORD_BITS = 16;
  localparam int ID_BITS    = 16;

  // Derived widths.
  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CFG_W  = 6;
  localparam int DU_W   = CFG_W + 1;
  localparam int IDX_W  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int FILL_W = $clog2(NEIGHBORS + 1);
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = 38;
  localparam int DIST_W = 37;
  localparam int RANK_W = 3;

  localparam logic [ACC_W-1:0]  ACC_MAX      = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_OUT_MAX = {DIST_W{1'b1}};
  localparam logic [CFG_W-1:0]  NUM_DIMS_RST = CFG_W'(30);

  // Stream widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = RANK_W + 1 + ID_BITS + DIST_W;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_CAND  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

endpackage

@@ sv/knn_top_k_distance_select.sv @@
// A query coordinate is stored from the stage-1 register; a candidate coordinate is
// summed and inserted from the stage-2 register. A readout copies the list from the
// stage-2 register, then gives one slot per cycle while out_tready is high; in_tready
// stays low until the final slot is taken. Throughput: one coordinate per cycle, set by
// the multiply and the accumulate-and-insert stages, while no readout is in flight.
// Reset: synchronous, active low; clears the pipeline, counters and list fill count.
module knn_top_k_distance_select (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: number of dimensions in use.
  input  logic                              cfg_wr_en,
  input  logic [knn_pkg::CFG_W-1:0]         cfg_wr_data,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [knn_pkg::IN_TDATA_W-1:0]    in_tdata,   // coord[15:0], candidate_id[31:16]
  input  logic [1:0]                        in_tuser,   // kind[1:0]
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [knn_pkg::OUT_TDATA_W-1:0]   out_tdata,  // rank[2:0], slot_valid[3],
                                                        // neighbor_id[19:4], distance[56:20]
  output logic                              out_tlast
);

  // Configuration register.
  logic [knn_pkg::CFG_W-1:0] num_dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= knn_pkg::NUM_DIMS_RST;
    end else if (cfg_wr_en) begin
      num_dims_r <= cfg_wr_data;
    end
  end

  // A register value of zero behaves as one dimension, and anything above the
  // maximum behaves as the maximum.
  logic [knn_pkg::DU_W-1:0] dims_use;

  always_comb begin
    if (num_dims_r == '0) begin
      dims_use = knn_pkg::DU_W'(1);
    end else if (knn_pkg::DU_W'(num_dims_r) > knn_pkg::DU_W'(knn_pkg::MAX_DIMS)) begin
      dims_use = knn_pkg::DU_W'(knn_pkg::MAX_DIMS);
    end else begin
      dims_use = knn_pkg::DU_W'(num_dims_r);
    end
  end

  // Input side: one dimension counter is shared by query and candidate
  // coordinates. It advances at the transfer itself, so the dimension and the
  // last-dimension flag travel down the pipeline with the item.
  logic                       in_xfer;
  knn_pkg::kind_t             in_kind;
  logic                       in_is_point;
  logic                       in_at_last;
  logic [knn_pkg::DIM_W-1:0]  dim_cnt_r;
  logic [knn_pkg::DIM_W-1:0]  dim_cnt_nxt;

  assign in_xfer     = in_tvalid && in_tready;
  assign in_kind     = knn_pkg::kind_t'(in_tuser);
  assign in_is_point = (in_kind == knn_pkg::KIND_QUERY) || (in_kind == knn_pkg::KIND_CAND);
  assign in_at_last  = (knn_pkg::DU_W'(dim_cnt_r) + knn_pkg::DU_W'(1)) >= dims_use;

  always_comb begin
    dim_cnt_nxt = dim_cnt_r;
    if (in_xfer && in_is_point) begin
      dim_cnt_nxt = in_at_last ? '0 : dim_cnt_r + knn_pkg::DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cnt_r <= '0;
    end else begin
      dim_cnt_r <= dim_cnt_nxt;
    end
  end

  // Stage 1: input register. Items of the unused kind are dropped here.
  logic                           s1_vld_r;
  knn_pkg::kind_t                 s1_kind_r;
  logic [knn_pkg::COORD_BITS-1:0] s1_coord_r;
  logic [knn_pkg::ID_BITS-1:0]    s1_id_r;
  logic [knn_pkg::DIM_W-1:0]      s1_dim_r;
  logic                           s1_last_r;
  logic                           s1_newq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer && (in_is_point || (in_kind == knn_pkg::KIND_READ));
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= in_kind;
    s1_coord_r <= in_tdata[knn_pkg::COORD_BITS-1:0];
    s1_id_r    <= in_tdata[16 +: knn_pkg::ID_BITS];
    s1_dim_r   <= dim_cnt_r;
    s1_last_r  <= in_at_last;
    // A query coordinate at dimension zero starts a new query.
    s1_newq_r  <= (in_kind == knn_pkg::KIND_QUERY) && (dim_cnt_r == '0);
  end

  // Query point storage, written and read in stage 1 so that every candidate
  // coordinate sees all query coordinates that were transferred before it.
  logic [knn_pkg::COORD_BITS-1:0] query_r [knn_pkg::MAX_DIMS];

  always_ff @(posedge clk) begin
    if (s1_vld_r && (s1_kind_r == knn_pkg::KIND_QUERY)) begin
      query_r[s1_dim_r] <= s1_coord_r;
    end
  end

  // Squared difference of one coordinate.
  logic [knn_pkg::COORD_BITS-1:0] q_val;
  logic signed [knn_pkg::MAG_W-1:0] diff;
  logic [knn_pkg::MAG_W-1:0]      mag;
  logic [knn_pkg::SQ_W-1:0]       sq;

  assign q_val = query_r[s1_dim_r];
  assign diff  = $signed({s1_coord_r[knn_pkg::COORD_BITS-1], s1_coord_r})
               - $signed({q_val[knn_pkg::COORD_BITS-1], q_val});
  assign mag   = diff[knn_pkg::MAG_W-1] ? knn_pkg::MAG_W'(-diff) : knn_pkg::MAG_W'(diff);
  assign sq    = knn_pkg::SQ_W'(mag) * knn_pkg::SQ_W'(mag);

  // Stage 2 register: the product and the control that goes with it.
  logic                        s2_vld_r;
  knn_pkg::kind_t              s2_kind_r;
  logic [knn_pkg::SQ_W-1:0]    s2_sq_r;
  logic [knn_pkg::ID_BITS-1:0] s2_id_r;
  logic                        s2_last_r;
  logic                        s2_newq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_sq_r   <= sq;
    s2_id_r   <= s1_id_r;
    s2_last_r <= s1_last_r;
    s2_newq_r <= s1_newq_r;
  end

  // Stage 2 work: accumulate the distance and, on the last dimension of a
  // candidate, insert it into the ascending neighbor list.
  logic                        s2_cand;
  logic                        s2_query;
  logic                        s2_read;
  logic [knn_pkg::ACC_W:0]     acc_sum;
  logic [knn_pkg::ACC_W-1:0]   dist_new;
  logic [knn_pkg::ACC_W-1:0]   acc_r;
  logic [knn_pkg::ACC_W-1:0]   acc_nxt;
  logic                        do_insert;

  assign s2_cand  = s2_vld_r && (s2_kind_r == knn_pkg::KIND_CAND);
  assign s2_query = s2_vld_r && (s2_kind_r == knn_pkg::KIND_QUERY);
  assign s2_read  = s2_vld_r && (s2_kind_r == knn_pkg::KIND_READ);

  // The running sum saturates at the accumulator's full scale.
  assign acc_sum  = (knn_pkg::ACC_W + 1)'(acc_r) + (knn_pkg::ACC_W + 1)'(s2_sq_r);
  assign dist_new = acc_sum[knn_pkg::ACC_W] ? knn_pkg::ACC_MAX : acc_sum[knn_pkg::ACC_W-1:0];

  // A candidate at distance zero, usually the query point itself, is skipped.
  assign do_insert = s2_cand && s2_last_r && (dist_new != '0);

  always_comb begin
    acc_nxt = acc_r;
    if (s2_cand || s2_query) begin
      if (s2_last_r) begin
        acc_nxt = '0;
      end else if (s2_cand) begin
        acc_nxt = dist_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Neighbor list. Only the first fill_r entries hold data.
  logic [knn_pkg::ACC_W-1:0]   list_dist_r [knn_pkg::NEIGHBORS];
  logic [knn_pkg::ID_BITS-1:0] list_id_r   [knn_pkg::NEIGHBORS];
  logic [knn_pkg::FILL_W-1:0]  fill_r;
  logic [knn_pkg::FILL_W-1:0]  fill_nxt;
  logic [knn_pkg::NEIGHBORS-1:0] gt;
  logic [knn_pkg::NEIGHBORS-1:0] take_new;
  logic [knn_pkg::NEIGHBORS-1:0] take_prev;

  // Each slot compares itself with the new distance. Entries strictly farther
  // move down one place; the new entry lands behind the last entry that is
  // nearer or equal. When the list is full and nothing is farther, nothing
  // changes.
  always_comb begin
    for (int i = 0; i < knn_pkg::NEIGHBORS; i++) begin
      gt[i] = (knn_pkg::FILL_W'(i) < fill_r) && (list_dist_r[i] > dist_new);
    end
    take_new[0]  = gt[0] || (fill_r == '0);
    take_prev[0] = 1'b0;
    for (int i = 1; i < knn_pkg::NEIGHBORS; i++) begin
      take_new[i]  = !gt[i-1] && (gt[i] || (knn_pkg::FILL_W'(i) == fill_r));
      take_prev[i] = gt[i-1] && (knn_pkg::FILL_W'(i) <= fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < knn_pkg::NEIGHBORS; i++) begin
        if (take_new[i]) begin
          list_dist_r[i] <= dist_new;
          list_id_r[i]   <= s2_id_r;
        end
      end
      for (int i = 1; i < knn_pkg::NEIGHBORS; i++) begin
        if (take_prev[i]) begin
          list_dist_r[i] <= list_dist_r[i-1];
          list_id_r[i]   <= list_id_r[i-1];
        end
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (s2_query && s2_newq_r) begin
      fill_nxt = '0;
    end else if (do_insert && (fill_r < knn_pkg::FILL_W'(knn_pkg::NEIGHBORS))) begin
      fill_nxt = fill_r + knn_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Readout buffer. A readout copies the list as it stands after every earlier
  // item, so the result fields come from registers that hold still while the
  // slots drain.
  logic [knn_pkg::ACC_W-1:0]   ro_dist_r [knn_pkg::NEIGHBORS];
  logic [knn_pkg::ID_BITS-1:0] ro_id_r   [knn_pkg::NEIGHBORS];
  logic [knn_pkg::FILL_W-1:0]  ro_fill_r;
  logic [knn_pkg::IDX_W-1:0]   ro_cnt_r;
  logic [knn_pkg::IDX_W-1:0]   ro_cnt_nxt;
  logic                        ro_busy_r;
  logic                        ro_busy_nxt;
  logic                        out_xfer;
  logic                        ro_final;

  assign out_xfer = out_tvalid && out_tready;
  assign ro_final = (ro_cnt_r == knn_pkg::IDX_W'(knn_pkg::NEIGHBORS - 1));

  always_comb begin
    ro_busy_nxt = ro_busy_r;
    ro_cnt_nxt  = ro_cnt_r;
    if (s2_read) begin
      ro_busy_nxt = 1'b1;
      ro_cnt_nxt  = '0;
    end else if (out_xfer) begin
      if (ro_final) begin
        ro_busy_nxt = 1'b0;
      end else begin
        ro_cnt_nxt = ro_cnt_r + knn_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ro_busy_r <= 1'b0;
      ro_cnt_r  <= '0;
    end else begin
      ro_busy_r <= ro_busy_nxt;
      ro_cnt_r  <= ro_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_read) begin
      ro_dist_r <= list_dist_r;
      ro_id_r   <= list_id_r;
      ro_fill_r <= fill_r;
    end
  end

  // Only one readout is in flight: a new item is refused from the transfer of a
  // readout until its final slot has been taken.
  logic s1_read;

  assign s1_read   = s1_vld_r && (s1_kind_r == knn_pkg::KIND_READ);
  assign in_tready = !(s1_read || s2_read || ro_busy_r);

  // Result fields. Empty slots report zero id and zero distance, and the
  // distance field saturates at its own full scale.
  logic                         slot_valid;
  logic [knn_pkg::ACC_W-1:0]    slot_dist;
  logic [knn_pkg::DIST_W-1:0]   out_dist;
  logic [knn_pkg::ID_BITS-1:0]  out_id;
  logic [knn_pkg::RANK_W-1:0]   out_rank;

  assign slot_valid = knn_pkg::FILL_W'(ro_cnt_r) < ro_fill_r;
  assign slot_dist  = slot_valid ? ro_dist_r[ro_cnt_r] : '0;
  assign out_dist   = (slot_dist > knn_pkg::ACC_W'(knn_pkg::DIST_OUT_MAX))
                    ? knn_pkg::DIST_OUT_MAX : slot_dist[knn_pkg::DIST_W-1:0];
  assign out_id     = slot_valid ? ro_id_r[ro_cnt_r] : '0;
  assign out_rank   = knn_pkg::RANK_W'(ro_cnt_r);

  assign out_tvalid = ro_busy_r;
  assign out_tlast  = ro_final;
  assign out_tdata  = {(knn_pkg::OUT_TDATA_W - knn_pkg::OUT_FIELD_W)'(0),
                       out_dist, out_id, slot_valid, out_rank};

`ifndef SYNTH
  // The list never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= knn_pkg::FILL_W'(knn_pkg::NEIGHBORS))
    else $error("neighbor list fill count beyond its size");

  // A readout reaching the list never finds the readout buffer still in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_read |-> !ro_busy_r)
    else $error("readout overlaps a readout still draining");

  // After the final slot is taken, no result follows in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> !out_tvalid)
    else $error("result presented right after the end of a readout");

  // A result stalled by the receiver keeps its slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(ro_cnt_r))
    else $error("readout slot moved while stalled");
`endif

endmodule

@@ tb/knn_top_k_distance_select_tb.sv @@
`timescale 1ns / 1ps

module knn_top_k_distance_select_tb;

  // Kind code that the block accepts and drops without any effect.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 19;      // chance in percent that a side idles in a cycle
  localparam int RANDOM_ITEMS  = 100;     // counted transfers in the random part
  localparam int SETTLE_CYCLES = 6;       // lets the last coordinates pass the pipeline registers
  localparam int TAIL_CYCLES   = 20;      // watch for stray results once nothing is expected
  localparam int HOLD_CYCLES   = 60;      // long receiver hold-off in the back-pressure test
  localparam int CYCLE_LIMIT   = 20000;   // watchdog, far above the slowest correct run

  localparam int COORD_MAX = 2 ** (knn_pkg::COORD_BITS - 1) - 1;
  localparam int COORD_MIN = -(2 ** (knn_pkg::COORD_BITS - 1));

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [knn_pkg::CFG_W-1:0]       cfg_wr_data = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [knn_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;  // coord[15:0], candidate_id[31:16]
  logic [1:0]                      in_tuser    = '0;  // kind[1:0]
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [knn_pkg::OUT_TDATA_W-1:0] out_tdata;         // rank[2:0], slot_valid[3],
                                                      // neighbor_id[19:4], distance[56:20]
  logic                            out_tlast;

  knn_top_k_distance_select uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // One slot of a neighbor-list readout, as the block should present it.
  typedef struct {
    logic [knn_pkg::RANK_W-1:0]  rank;
    logic                        slot_valid;
    logic [knn_pkg::ID_BITS-1:0] neighbor_id;
    logic [knn_pkg::DIST_W-1:0]  distance;
    logic                        last;
  } slot_t;

  slot_t expected_slots[$];

  // Shadow copy of the selector state, advanced on every accepted input transfer.
  logic signed [knn_pkg::COORD_BITS-1:0] query_pt[knn_pkg::MAX_DIMS];
  bit                                    query_loaded[knn_pkg::MAX_DIMS];
  int unsigned                           dim_pos;
  longint unsigned                       dist_sum;
  longint unsigned                       nbr_dist[knn_pkg::NEIGHBORS];
  logic [knn_pkg::ID_BITS-1:0]           nbr_id[knn_pkg::NEIGHBORS];
  int unsigned                           nbr_count;
  logic [knn_pkg::CFG_W-1:0]             dims_reg;

  int unsigned fail_count;
  int unsigned items_sent;
  bit          no_idle;    // both sides run without random idling while set
  int unsigned hold_req;   // asks the receiver for a hold-off of this many cycles
  slot_t       want_slot;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Register value 0 behaves as one dimension, anything above the array size as the maximum.
  function automatic int unsigned dims_active();
    if (dims_reg == 0) return 1;
    if (dims_reg > knn_pkg::MAX_DIMS) return knn_pkg::MAX_DIMS;
    return 32'(dims_reg);
  endfunction

  // Insert into the ascending list behind entries of equal distance. When the list is full
  // the newcomer must be strictly nearer than the current worst entry, which falls off.
  function automatic void rank_insert(longint unsigned d, logic [knn_pkg::ID_BITS-1:0] id);
    int unsigned pos;
    int unsigned top;
    pos = 0;
    while (pos < nbr_count && nbr_dist[pos] <= d) pos++;
    if (nbr_count < knn_pkg::NEIGHBORS) begin
      top = nbr_count;
      nbr_count++;
    end else begin
      if (d >= nbr_dist[knn_pkg::NEIGHBORS-1]) return;
      top = knn_pkg::NEIGHBORS - 1;
    end
    for (int unsigned i = top; i > pos; i--) begin
      nbr_dist[i] = nbr_dist[i-1];
      nbr_id[i]   = nbr_id[i-1];
    end
    nbr_dist[pos] = d;
    nbr_id[pos]   = id;
  endfunction

  // Query and candidate coordinates share one dimension counter; it wraps, and the running
  // sum clears, on the last dimension in use.
  function automatic void step_dim(bit at_last);
    if (at_last) begin
      dim_pos  = 0;
      dist_sum = 0;
    end else begin
      dim_pos++;
    end
  endfunction

  // Advance the shadow state by one accepted transfer and queue any readout slots.
  // At these sizes the squared sum never reaches the accumulator's saturation point.
  function automatic void track_knn_item(logic [1:0] kind,
                                         logic signed [knn_pkg::COORD_BITS-1:0] c,
                                         logic [knn_pkg::ID_BITS-1:0] id);
    bit      at_last;
    longint  diff;
    slot_t   s;
    at_last = (dim_pos + 1) >= dims_active();
    case (kind)
      knn_pkg::KIND_QUERY: begin
        // A query coordinate at dimension zero starts a new query and empties the list.
        if (dim_pos == 0) nbr_count = 0;
        query_pt[dim_pos]     = c;
        query_loaded[dim_pos] = 1'b1;
        step_dim(at_last);
      end
      knn_pkg::KIND_CAND: begin
        diff     = longint'(c) - longint'(query_pt[dim_pos]);
        dist_sum = dist_sum + longint'(diff * diff);
        // A candidate sitting exactly on the query is never listed.
        if (at_last && dist_sum != 0) rank_insert(dist_sum, id);
        step_dim(at_last);
      end
      knn_pkg::KIND_READ: begin
        for (int r = 0; r < knn_pkg::NEIGHBORS; r++) begin
          s.rank        = knn_pkg::RANK_W'(r);
          s.slot_valid  = (r < int'(nbr_count));
          s.neighbor_id = s.slot_valid ? nbr_id[r] : '0;
          if (!s.slot_valid) s.distance = '0;
          else if (nbr_dist[r] > 64'(knn_pkg::DIST_OUT_MAX)) s.distance = knn_pkg::DIST_OUT_MAX;
          else s.distance = knn_pkg::DIST_W'(nbr_dist[r]);
          s.last = (r == knn_pkg::NEIGHBORS - 1);
          expected_slots.push_back(s);
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item and hold it until the block takes it. Called and returning at a falling
  // edge, so valid and data change only there and exactly once per step.
  task automatic send_item(input logic [1:0] kind,
                           input logic signed [knn_pkg::COORD_BITS-1:0] c,
                           input logic [knn_pkg::ID_BITS-1:0] id);
    logic [1:0] k;
    k = kind;
    // Never let a candidate meet a query coordinate that was not loaded.
    if (k == knn_pkg::KIND_CAND && !query_loaded[dim_pos]) k = knn_pkg::KIND_QUERY;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {id, c};
    do @(posedge clk); while (!in_tready);
    track_knn_item(k, c, id);
    if (k != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Stop offering, let every expected slot arrive, then let the pipeline empty.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (expected_slots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dims(input logic [knn_pkg::CFG_W-1:0] v);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dims_reg = v;
  endtask

  function automatic logic signed [knn_pkg::COORD_BITS-1:0] near_coord(int spread);
    int v;
    v = int'(query_pt[dim_pos]) + int'($urandom_range(2 * spread)) - spread;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[knn_pkg::COORD_BITS-1:0];
  endfunction

  // Bring the counter back to dimension zero, then load a full query point, either over
  // the whole range or packed near the origin.
  task automatic load_query(input bit wide);
    int c;
    while (dim_pos != 0) begin
      send_item(knn_pkg::KIND_QUERY, knn_pkg::COORD_BITS'($urandom),
                knn_pkg::ID_BITS'($urandom));
    end
    for (int unsigned d = 0; d < dims_active(); d++) begin
      c = wide ? int'($urandom) : int'($urandom_range(16)) - 8;
      send_item(knn_pkg::KIND_QUERY, c[knn_pkg::COORD_BITS-1:0], knn_pkg::ID_BITS'($urandom));
    end
  endtask

  // One candidate point: mode 0 anywhere, mode 1 close to the query (many ties),
  // mode 2 on the query itself.
  task automatic send_candidate(input logic [knn_pkg::ID_BITS-1:0] id, input int mode);
    logic signed [knn_pkg::COORD_BITS-1:0] c;
    for (int unsigned d = 0; d < dims_active(); d++) begin
      if (mode == 0 || !query_loaded[dim_pos]) c = knn_pkg::COORD_BITS'($urandom);
      else if (mode == 1) c = near_coord(3);
      else c = query_pt[dim_pos];
      send_item(knn_pkg::KIND_CAND, c, id);
    end
  endtask

  task automatic cand2(input logic [knn_pkg::ID_BITS-1:0] id, input int x, input int y);
    send_item(knn_pkg::KIND_CAND, x[knn_pkg::COORD_BITS-1:0], id);
    send_item(knn_pkg::KIND_CAND, y[knn_pkg::COORD_BITS-1:0], id);
  endtask

  // Straight after reset the list is empty: every slot reads back as unused.
  task automatic test_empty_readout();
    send_item(knn_pkg::KIND_READ, '0, '0);
  endtask

  // Ordering, ties, the zero-distance skip, the full-list rule and the extreme coordinates.
  task automatic test_ranking();
    write_dims(6'd2);
    send_item(knn_pkg::KIND_QUERY, 16'sd0, '0);
    send_item(knn_pkg::KIND_QUERY, 16'sd0, '0);
    cand2(16'hFFFF, COORD_MIN, COORD_MAX);  // extreme coordinates, the farthest candidate here
    cand2(16'd0, 0, 0);                     // on the query, dropped
    cand2(16'd1, 3, 4);                     // 25
    cand2(16'd2, -3, -4);                   // 25, behind id 1
    cand2(16'd3, 5, 0);                     // 25, behind id 2
    cand2(16'd4, 1, 0);                     // 1, moves to the front, list now full
    cand2(16'd5, 0, -5);                    // 25 beats the far one and pushes it out
    cand2(16'd6, 7, 7);                     // 98, too far
    cand2(16'd7, -5, 0);                    // ties the worst entry, rejected
    send_item(knn_pkg::KIND_READ, '0, '0);
    // The unused kind must leave the list and the counter alone.
    send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(knn_pkg::KIND_READ, 16'hFFFF, 16'hFFFF);
    settle_idle();
  endtask

  // Register value zero acts as a single dimension; full-scale coordinate difference.
  task automatic test_dims_limits();
    write_dims(6'd0);
    send_item(knn_pkg::KIND_QUERY, COORD_MAX[knn_pkg::COORD_BITS-1:0], '0);
    send_item(knn_pkg::KIND_CAND, COORD_MAX[knn_pkg::COORD_BITS-1:0], 16'd10);
    send_item(knn_pkg::KIND_CAND, COORD_MIN[knn_pkg::COORD_BITS-1:0], 16'd11);
    send_item(knn_pkg::KIND_CAND, 16'sh7FFE, 16'd12);
    send_item(knn_pkg::KIND_READ, '0, '0);
    settle_idle();
  endtask

  // Lowering num_dims while the counter is deep into a point: the counter then already
  // sits at or past the new last dimension and must wrap on the next coordinate.
  task automatic test_shrink_dims();
    write_dims(6'd8);
    repeat (5) begin
      send_item(knn_pkg::KIND_QUERY, knn_pkg::COORD_BITS'($urandom),
                knn_pkg::ID_BITS'($urandom));
    end
    write_dims(6'd3);
    send_item(knn_pkg::KIND_QUERY, knn_pkg::COORD_BITS'($urandom),
              knn_pkg::ID_BITS'($urandom));
    send_candidate(knn_pkg::ID_BITS'($urandom), 0);
    send_candidate(knn_pkg::ID_BITS'($urandom), 1);
    send_item(knn_pkg::KIND_READ, '0, '0);
    settle_idle();
  endtask

  // The receiver stops for a long time while readouts keep coming, so the result path
  // fills and the block has to hold its input back. Afterwards the sender waits for
  // every outstanding slot before going on.
  task automatic test_backpressure();
    write_dims(6'd2);
    load_query(1'b0);
    hold_req = HOLD_CYCLES;
    send_candidate(knn_pkg::ID_BITS'($urandom), 1);
    send_candidate(knn_pkg::ID_BITS'($urandom), 1);
    send_item(knn_pkg::KIND_READ, '0, '0);
    send_item(knn_pkg::KIND_READ, '0, '0);
    send_candidate(knn_pkg::ID_BITS'($urandom), 0);
    send_item(knn_pkg::KIND_READ, '0, '0);
    settle_idle();
  endtask

  // A stretch with neither side idling: one transfer per cycle where the block allows it.
  task automatic test_full_rate();
    no_idle = 1'b1;
    write_dims(6'd4);
    load_query(1'b0);
    for (int i = 0; i < 6; i++) send_candidate(knn_pkg::ID_BITS'($urandom), i % 3);
    send_item(knn_pkg::KIND_READ, '0, '0);
    send_item(knn_pkg::KIND_READ, '0, '0);
    settle_idle();
    no_idle = 1'b0;
  endtask

  // Phases of random setting, query and candidates. Most points are well formed; stray
  // query coordinates and single candidate coordinates shift the framing now and then,
  // and unused kinds are mixed in. Small point sizes dominate; the first phase uses a
  // register value above the maximum, so its points run over the full range of dimensions.
  task automatic test_random();
    int unsigned start_count;
    int unsigned phase;
    int unsigned nd_pick;
    int unsigned n_cand;
    int unsigned r;
    int unsigned m;
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case (phase)
        0: nd_pick = 63;
        2: nd_pick = 1;
        default: nd_pick = $urandom_range(1, 5);
      endcase
      write_dims(knn_pkg::CFG_W'(nd_pick));
      load_query(1'($urandom_range(1)));
      n_cand = (dims_active() > 8) ? 1 : $urandom_range(3, 8);
      repeat (n_cand) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_item(KIND_UNUSED, knn_pkg::COORD_BITS'($urandom), knn_pkg::ID_BITS'($urandom));
        end else if (r < 12) begin
          send_item(knn_pkg::KIND_QUERY, knn_pkg::COORD_BITS'($urandom),
                    knn_pkg::ID_BITS'($urandom));
        end else if (r < 17) begin
          send_item(knn_pkg::KIND_CAND, knn_pkg::COORD_BITS'($urandom),
                    knn_pkg::ID_BITS'($urandom));
        end
        m = $urandom_range(99);
        send_candidate(knn_pkg::ID_BITS'($urandom), (m < 10) ? 2 : (m < 55) ? 1 : 0);
        if ($urandom_range(3) == 0) begin
          send_item(knn_pkg::KIND_READ, knn_pkg::COORD_BITS'($urandom),
                    knn_pkg::ID_BITS'($urandom));
        end
      end
      send_item(knn_pkg::KIND_READ, knn_pkg::COORD_BITS'($urandom),
                knn_pkg::ID_BITS'($urandom));
      phase++;
    end
    settle_idle();
  endtask

  // Result side: random stalls, the requested long hold-off, or always ready.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Every result transfer is matched against the oldest slot still expected.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_slots.size() == 0) begin
        fail_count++;
        $error("result transfer with nothing expected: %h", out_tdata);
      end else begin
        want_slot = expected_slots.pop_front();
        check_field("rank", 64'(want_slot.rank), 64'(out_tdata[knn_pkg::RANK_W-1:0]));
        check_field("slot_valid", 64'(want_slot.slot_valid),
                    64'(out_tdata[knn_pkg::RANK_W]));
        check_field("neighbor_id", 64'(want_slot.neighbor_id),
                    64'(out_tdata[knn_pkg::RANK_W+1 +: knn_pkg::ID_BITS]));
        check_field("distance", 64'(want_slot.distance),
                    64'(out_tdata[knn_pkg::RANK_W+1+knn_pkg::ID_BITS +: knn_pkg::DIST_W]));
        check_field("last", 64'(want_slot.last), 64'(out_tlast));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    dims_reg = knn_pkg::NUM_DIMS_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_readout();
    test_ranking();
    test_dims_limits();
    test_shrink_dims();
    test_backpressure();
    test_full_rate();
    test_random();
    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_slots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
